// ===== rtl/core/fixed_block_pool_allocator_unit_defines.svh =====
// assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FBPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbpa check failed");

// consequent checked in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbpa check failed");

`endif

// ===== rtl/core/fbpa_pkg.sv =====
`timescale 1ns / 1ps

package fbpa_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W    = 16;
  localparam int BCNT_W    = 9;

  // parameter defaults
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ADDR_BITS_DEF  = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FOREIGN  = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // register reset values
  localparam logic [DATA_W-1:0] RST_POOL_BASE   = 32'd0;
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 16'd8;
  localparam logic [BCNT_W-1:0] RST_BLOCK_COUNT = 9'd256;
  localparam int                RST_COUNT_INT   = 256;

  // smallest usable block
  localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = 16'd8;

endpackage

// ===== rtl/core/fbpa_stack.sv =====
`timescale 1ns / 1ps

// freed-block stack storage, one write and one registered read per cycle
module fbpa_stack #(
  parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int WIDTH = fbpa_pkg::ADDR_BITS_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/fixed_block_pool_allocator_unit.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | tdata: free_address; tuser: opcode
// m_*       | out | m_tvalid/m_tready  | tdata: block_address; tuser: status
// cfg_*     | in  | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// each word passes through accept and execute: the accept cycle reads the stack top and
// forms the block offset products, then the execute state decides and updates the stack
// the stack memory's registered read is what sets this split
// rst is synchronous, active high; the stack contents are not cleared
// a result waits in the output register; a new word is still taken meanwhile,
// and its execute cycle holds until the output register is free
module fixed_block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fbpa_pkg::DATA_W-1:0]     s_tdata,   // [31:0] free_address
  input  logic [fbpa_pkg::OP_W-1:0]       s_tuser,   // [1:0] opcode
  // result words
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fbpa_pkg::DATA_W-1:0]     m_tdata,   // [31:0] block_address
  output logic [fbpa_pkg::ST_W-1:0]       m_tuser,   // [1:0] status
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::DATA_W-1:0]     cfg_data
);

  // counter, index and arithmetic widths
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PROD_W = CNT_W + fbpa_pkg::SIZE_W;
  localparam int XW0    = (ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W;
  localparam int XW     = (XW0 > fbpa_pkg::DATA_W) ? XW0 : fbpa_pkg::DATA_W;
  localparam int CMP_W  = (CNT_W > fbpa_pkg::BCNT_W) ? CNT_W : fbpa_pkg::BCNT_W;
  localparam int RST_UL = (fbpa_pkg::RST_COUNT_INT > MAX_BLOCKS) ? MAX_BLOCKS
                                                                 : fbpa_pkg::RST_COUNT_INT;
  localparam logic [XW-1:0] ADDR_MASK = {XW{1'b1}} >> (XW - ADDR_BITS);

  // sequencer
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  // configuration registers
  logic [fbpa_pkg::DATA_W-1:0]  pool_base;
  logic [fbpa_pkg::SIZE_W-1:0]  block_size;
  logic [fbpa_pkg::BCNT_W-1:0]  block_count;

  // pool counters
  logic [CNT_W-1:0] depth, depth_next;
  logic [CNT_W-1:0] untouched, untouched_next;

  // word latched at accept
  logic [fbpa_pkg::OP_W-1:0] op_r;
  logic [ADDR_BITS-1:0]      faddr_r;
  logic [XW-1:0]             off_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W-1:0]         span_r;
  logic [CNT_W-1:0]          cnt_r;

  // effective settings
  logic [fbpa_pkg::SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]            eff_cnt;
  logic [CMP_W-1:0]            bc_ext;

  logic accept, out_free, exec_go;
  logic [CNT_W-1:0] depth_dec, untouched_dec;

  // stack port
  logic                 wr_en;
  logic [ADDR_BITS-1:0] rd_data;

  // result
  logic [XW-1:0]               res_addr;
  logic [fbpa_pkg::ST_W-1:0]   res_st;
  logic [XW-1:0]               alloc_addr;
  logic                        full;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign exec_go   = (state == ST_EXEC) && out_free;

  // sizes below the minimum are raised, counts above the stack depth are clipped
  assign eff_size = (block_size < fbpa_pkg::MIN_BLOCK_SIZE) ? fbpa_pkg::MIN_BLOCK_SIZE
                                                            : block_size;
  assign bc_ext   = CMP_W'(block_count);
  assign eff_cnt  = (bc_ext > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bc_ext);

  assign depth_dec     = depth - CNT_W'(1);
  assign untouched_dec = untouched - CNT_W'(1);

  fbpa_stack #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (ADDR_BITS)
  ) u_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (depth_dec[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (depth[IDX_W-1:0]),
    .wr_data (faddr_r)
  );

  // untouched blocks come out from the top of the pool downwards
  assign alloc_addr = (XW'(pool_base) + XW'(prod_r)) & ADDR_MASK;
  // no room for another free once stack plus untouched cover the pool
  assign full = ({1'b0, depth} + {1'b0, untouched} >= {1'b0, cnt_r}) ||
                (depth >= CNT_W'(MAX_BLOCKS));

  always_comb begin
    depth_next     = depth;
    untouched_next = untouched;
    res_addr       = '0;
    res_st         = fbpa_pkg::ST_OK;
    wr_en          = 1'b0;
    unique case (op_r)
      fbpa_pkg::OP_ALLOC: begin
        if (depth != '0) begin
          depth_next = depth_dec;
          res_addr   = XW'(rd_data);
        end else if (untouched != '0) begin
          untouched_next = untouched_dec;
          res_addr       = alloc_addr;
        end else begin
          res_st = fbpa_pkg::ST_EMPTY;
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (off_r >= XW'(span_r)) begin
          res_st = fbpa_pkg::ST_FOREIGN;
        end else if (full) begin
          res_st = fbpa_pkg::ST_OVERFLOW;
        end else begin
          wr_en      = exec_go;
          depth_next = depth + CNT_W'(1);
        end
      end
      fbpa_pkg::OP_RESTART: begin
        depth_next     = '0;
        untouched_next = cnt_r;
      end
      default: begin
        // unused opcode answers ok and leaves the pool alone
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      depth       <= '0;
      untouched   <= CNT_W'(RST_UL);
      m_tvalid    <= 1'b0;
      pool_base   <= fbpa_pkg::RST_POOL_BASE;
      block_size  <= fbpa_pkg::RST_BLOCK_SIZE;
      block_count <= fbpa_pkg::RST_BLOCK_COUNT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fbpa_pkg::CFG_POOL_BASE) begin
          pool_base <= cfg_data;
        end else if (cfg_index == fbpa_pkg::CFG_BLOCK_SIZE) begin
          block_size <= cfg_data[fbpa_pkg::SIZE_W-1:0];
        end else if (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT) begin
          block_count <= cfg_data[fbpa_pkg::BCNT_W-1:0];
        end
      end
      if (accept) begin
        state <= ST_EXEC;
      end else if (exec_go) begin
        state <= ST_IDLE;
      end
      if (exec_go) begin
        depth     <= depth_next;
        untouched <= untouched_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= s_tuser;
      faddr_r <= ADDR_BITS'(s_tdata);
      off_r   <= (XW'(s_tdata) - XW'(pool_base)) & ADDR_MASK;
      prod_r  <= PROD_W'(untouched_dec) * PROD_W'(eff_size);
      span_r  <= PROD_W'(eff_cnt) * PROD_W'(eff_size);
      cnt_r   <= eff_cnt;
    end
    if (exec_go) begin
      m_tdata <= res_addr[fbpa_pkg::DATA_W-1:0];
      m_tuser <= res_st;
    end
  end

endmodule

// ===== rtl/core/fbpa_checker.sv =====
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_unit_defines.svh"

module fbpa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [fbpa_pkg::DATA_W-1:0]  m_tdata,
  input logic [fbpa_pkg::ST_W-1:0]    m_tuser
);

  // one word at a time: no accept right after an accept
  `FBPA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // only a successful allocate carries an address
  `FBPA_ASSERT_SAME(a_zero_addr, m_tvalid && (m_tuser != fbpa_pkg::ST_OK), m_tdata == '0)

  // stalled result holds
  `FBPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);
